// ===== hw/rtl/xold_pkg.sv =====
// Types, opcode constants and lookup tables for the x86 opcode length decoder.
package xold_pkg;

   typedef struct packed {
      logic [7:0] opcode_byte;
      logic       addr_size_32;
      logic       oper_size_32;
   } req_type;

   typedef struct packed {
      logic       two_byte_map;
      logic [7:0] opcode_value;
      logic       modrm_needed;
      logic [2:0] disp_bytes;
      logic       far_pointer;
      logic [2:0] imm_bytes;
      logic [3:0] group_number;
   } rsp_type;

   // One bit per opcode: row is the high nibble, column 0 is the most significant bit.
   typedef logic [0:15][15:0] opcode_map_type;

   localparam logic [7:0] ESCAPE_CODE   = 8'h0F;
   localparam logic [7:0] CALL_FAR_CODE = 8'h9A;
   localparam logic [7:0] JMP_FAR_CODE  = 8'hEA;
   localparam logic [7:0] RET_IMM_CODE  = 8'hC2;
   localparam logic [7:0] RETF_IMM_CODE = 8'hCA;
   localparam logic [7:0] ENTER_CODE    = 8'hC8;

   localparam opcode_map_type MODRM_MAP1 = {
      16'hF0F0, 16'hF0F0, 16'hF0F0, 16'hF0F0, 16'h0000, 16'h0000, 16'h3050, 16'h0000,
      16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hCF00, 16'hF000, 16'h0000, 16'h0303};
   localparam opcode_map_type MODRM_MAP2 = {
      16'hB000, 16'h0000, 16'hF000, 16'hF000, 16'hFFFF, 16'h0000, 16'hFFF3, 16'h7E03,
      16'h0000, 16'hFFFF, 16'h1C1D, 16'hFF3F, 16'hC100, 16'h74DD, 16'h64DD, 16'h74EE};
   localparam opcode_map_type DISP8_MAP1 = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
      16'h0000, 16'h0000, 16'hA000, 16'h0000, 16'h0000, 16'h0000, 16'hF010, 16'h0000};
   localparam opcode_map_type DISPV_MAP1 = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h5000, 16'h0000, 16'h0000, 16'h0000, 16'h00C0, 16'h0000};
   localparam opcode_map_type DISPV_MAP2 = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
   localparam opcode_map_type IMM8_MAP1 = {
      16'h0808, 16'h0808, 16'h0808, 16'h0808, 16'h0000, 16'h0000, 16'h0030, 16'h0000,
      16'h0000, 16'h0000, 16'h0080, 16'hFF00, 16'h0200, 16'h0000, 16'h0F00, 16'h0000};
   localparam opcode_map_type IMMV_MAP1 = {
      16'h0404, 16'h0404, 16'h0404, 16'h0404, 16'h0000, 16'h0000, 16'h00C0, 16'h0000,
      16'h0000, 16'h0000, 16'h0040, 16'h00FF, 16'h0100, 16'h0000, 16'h0000, 16'h0000};
   localparam opcode_map_type IMM8_MAP2 = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0808, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};

   function automatic logic map_bit(input opcode_map_type map, input logic [7:0] code);
      return map[code[7:4]][4'd15 - code[3:0]];
   endfunction

   function automatic logic [3:0] group_of(input logic [7:0] code, input logic two_byte);
      logic [3:0] grp;
      grp = 4'd0;
      if (!two_byte) begin
         if (code >= 8'h80 && code <= 8'h83) begin
            grp = 4'd1;
         end else if (code == 8'hC0 || code == 8'hC1 || (code >= 8'hD0 && code <= 8'hD3)) begin
            grp = 4'd2;
         end else if (code == 8'hF6 || code == 8'hF7) begin
            grp = 4'd3;
         end else if (code == 8'hFE) begin
            grp = 4'd4;
         end else if (code == 8'hFF) begin
            grp = 4'd5;
         end
      end else begin
         if (code == 8'h00) begin
            grp = 4'd6;
         end else if (code == 8'h01) begin
            grp = 4'd7;
         end else if (code == 8'hC7) begin
            grp = 4'd9;
         end else if (code >= 8'h71 && code <= 8'h73) begin
            grp = 4'd10;
         end
      end
      return grp;
   endfunction

endpackage

// ===== hw/rtl/xold_decode.sv =====
// Combinational opcode table lookup that sizes the operands of one opcode byte.
module xold_decode (
   input  xold_pkg::req_type item,
   input  logic              escape_seen,
   output logic              is_escape,
   output xold_pkg::rsp_type result
);
   import xold_pkg::*;

   logic [7:0] code;
   logic       a32;
   logic       o32;
   logic [2:0] var_disp;
   logic [2:0] var_imm;

   assign code     = item.opcode_byte;
   assign a32      = item.addr_size_32;
   assign o32      = item.oper_size_32;
   assign var_disp = a32 ? 3'd4 : 3'd2;
   assign var_imm  = o32 ? 3'd4 : 3'd2;

   assign is_escape = !escape_seen && (code == ESCAPE_CODE);

   always_comb begin
      result              = '0;
      result.two_byte_map = escape_seen;
      result.opcode_value = code;
      result.group_number = group_of(code, escape_seen);
      if (!escape_seen) begin
         result.modrm_needed = map_bit(MODRM_MAP1, code);
         priority if (code == CALL_FAR_CODE || code == JMP_FAR_CODE) begin
            result.disp_bytes  = a32 ? 3'd6 : 3'd4;
            result.far_pointer = 1'b1;
         end else if (map_bit(DISP8_MAP1, code)) begin
            result.disp_bytes = 3'd1;
         end else if (map_bit(DISPV_MAP1, code)) begin
            result.disp_bytes = var_disp;
         end else begin
            result.disp_bytes = 3'd0;
         end
         priority if (code == RET_IMM_CODE || code == RETF_IMM_CODE) begin
            result.imm_bytes = 3'd2;
         end else if (code == ENTER_CODE) begin
            result.imm_bytes = 3'd3;
         end else if (map_bit(IMM8_MAP1, code)) begin
            result.imm_bytes = 3'd1;
         end else if (map_bit(IMMV_MAP1, code)) begin
            result.imm_bytes = var_imm;
         end else begin
            result.imm_bytes = 3'd0;
         end
      end else begin
         result.modrm_needed = map_bit(MODRM_MAP2, code);
         result.disp_bytes   = map_bit(DISPV_MAP2, code) ? var_disp : 3'd0;
         result.imm_bytes    = map_bit(IMM8_MAP2, code) ? 3'd1 : 3'd0;
      end
   end

endmodule

// ===== hw/rtl/x86_opcode_length_decode.sv =====
// Top level of the x86 opcode length decoder with escape tracking and result register.
// Each request transaction carries one opcode byte that follows any prefixes, with the
// effective address and operand size flags. A 0x0F byte outside the two-byte map only
// arms the escape and returns no response; every other byte returns one response, in the
// cycle after acceptance, giving the map, ModR/M presence, displacement and immediate
// sizes and the extension group. The decoder accepts one byte every cycle; the single
// result register stalls the request side only while a response waits and rsp_ready
// is low.
module x86_opcode_length_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xold_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xold_pkg::rsp_type rsp_payload
);
   import xold_pkg::*;

   logic    escape_ff;
   logic    escape_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   rsp_type decoded;
   logic    is_escape;
   logic    req_fire;

   xold_decode u_decode (
      .item       (req_payload),
      .escape_seen(escape_ff),
      .is_escape  (is_escape),
      .result     (decoded)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      escape_in    = escape_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (req_fire) begin
         escape_in = is_escape;
         if (!is_escape) begin
            rsp_valid_in = 1'b1;
            rsp_in       = decoded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         escape_ff    <= escape_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/testbench.sv =====
// Testbench for the x86 opcode length decoder: byte streams checked against a predictor.
`timescale 1ns / 100ps

class decode_scoreboard;
   bit [255:0] modrm_one = {
      16'hF0F0, 16'hF0F0, 16'hF0F0, 16'hF0F0, 16'h0000, 16'h0000, 16'h3050, 16'h0000,
      16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hCF00, 16'hF000, 16'h0000, 16'h0303};
   bit [255:0] modrm_two = {
      16'hB000, 16'h0000, 16'hF000, 16'hF000, 16'hFFFF, 16'h0000, 16'hFFF3, 16'h7E03,
      16'h0000, 16'hFFFF, 16'h1C1D, 16'hFF3F, 16'hC100, 16'h74DD, 16'h64DD, 16'h74EE};
   bit [255:0] disp8_one = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
      16'h0000, 16'h0000, 16'hA000, 16'h0000, 16'h0000, 16'h0000, 16'hF010, 16'h0000};
   bit [255:0] dispv_one = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h5000, 16'h0000, 16'h0000, 16'h0000, 16'h00C0, 16'h0000};
   bit [255:0] dispv_two = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
   bit [255:0] imm8_one = {
      16'h0808, 16'h0808, 16'h0808, 16'h0808, 16'h0000, 16'h0000, 16'h0030, 16'h0000,
      16'h0000, 16'h0000, 16'h0080, 16'hFF00, 16'h0200, 16'h0000, 16'h0F00, 16'h0000};
   bit [255:0] immv_one = {
      16'h0404, 16'h0404, 16'h0404, 16'h0404, 16'h0000, 16'h0000, 16'h00C0, 16'h0000,
      16'h0000, 16'h0000, 16'h0040, 16'h00FF, 16'h0100, 16'h0000, 16'h0000, 16'h0000};
   bit [255:0] imm8_two = {
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0808, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};

   xold_pkg::rsp_type decode_q[$];
   bit                escape_armed;
   int unsigned       errors;

   function bit opcode_hit(bit [255:0] tbl, bit [7:0] code);
      return tbl[8'd255 - code];
   endfunction

   function bit [3:0] extension_group(bit [7:0] code, bit two_byte);
      if (!two_byte) begin
         if (code >= 8'h80 && code <= 8'h83) return 4'd1;
         if (code == 8'hC0 || code == 8'hC1 || (code >= 8'hD0 && code <= 8'hD3)) return 4'd2;
         if (code == 8'hF6 || code == 8'hF7) return 4'd3;
         if (code == 8'hFE) return 4'd4;
         if (code == 8'hFF) return 4'd5;
         return 4'd0;
      end
      if (code == 8'h00) return 4'd6;
      if (code == 8'h01) return 4'd7;
      if (code == 8'hC7) return 4'd9;
      if (code >= 8'h71 && code <= 8'h73) return 4'd10;
      return 4'd0;
   endfunction

   function void note_request(xold_pkg::req_type req);
      xold_pkg::rsp_type want;
      bit [7:0]          code;
      bit                two;
      code = req.opcode_byte;
      two  = escape_armed;
      if (!two && code == xold_pkg::ESCAPE_CODE) begin
         escape_armed = 1'b1;
         return;
      end
      want              = '0;
      want.two_byte_map = two;
      want.opcode_value = code;
      want.modrm_needed = opcode_hit(two ? modrm_two : modrm_one, code);
      if (!two) begin
         if (code == xold_pkg::CALL_FAR_CODE || code == xold_pkg::JMP_FAR_CODE) begin
            want.disp_bytes  = req.addr_size_32 ? 3'd6 : 3'd4;
            want.far_pointer = 1'b1;
         end else if (opcode_hit(disp8_one, code)) begin
            want.disp_bytes = 3'd1;
         end else if (opcode_hit(dispv_one, code)) begin
            want.disp_bytes = req.addr_size_32 ? 3'd4 : 3'd2;
         end
         if (code == xold_pkg::RET_IMM_CODE || code == xold_pkg::RETF_IMM_CODE) begin
            want.imm_bytes = 3'd2;
         end else if (code == xold_pkg::ENTER_CODE) begin
            want.imm_bytes = 3'd3;
         end else if (opcode_hit(imm8_one, code)) begin
            want.imm_bytes = 3'd1;
         end else if (opcode_hit(immv_one, code)) begin
            want.imm_bytes = req.oper_size_32 ? 3'd4 : 3'd2;
         end
      end else begin
         if (opcode_hit(dispv_two, code)) want.disp_bytes = req.addr_size_32 ? 3'd4 : 3'd2;
         if (opcode_hit(imm8_two, code)) want.imm_bytes = 3'd1;
      end
      want.group_number = extension_group(code, two);
      escape_armed = 1'b0;
      decode_q.push_back(want);
   endfunction

   function void compare_field(string name, bit [7:0] code, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: opcode %h %s expected %0d, actual %0d", $time, code, name, want, got);
      end
   endfunction

   function void check_response(xold_pkg::rsp_type got);
      xold_pkg::rsp_type want;
      if (decode_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected response, expected none, actual %h", $time, got);
         return;
      end
      want = decode_q.pop_front();
      compare_field("two_byte_map", want.opcode_value, 8'(want.two_byte_map),
                    8'(got.two_byte_map));
      compare_field("opcode_value", want.opcode_value, want.opcode_value, got.opcode_value);
      compare_field("modrm_needed", want.opcode_value, 8'(want.modrm_needed),
                    8'(got.modrm_needed));
      compare_field("disp_bytes", want.opcode_value, 8'(want.disp_bytes), 8'(got.disp_bytes));
      compare_field("far_pointer", want.opcode_value, 8'(want.far_pointer),
                    8'(got.far_pointer));
      compare_field("imm_bytes", want.opcode_value, 8'(want.imm_bytes), 8'(got.imm_bytes));
      compare_field("group_number", want.opcode_value, 8'(want.group_number),
                    8'(got.group_number));
   endfunction

   function int unsigned outstanding();
      return decode_q.size();
   endfunction
endclass

module testbench;
   localparam int unsigned RANDOM_ITEMS = 1950;
   localparam int unsigned CYCLE_LIMIT  = 300000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   xold_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   xold_pkg::rsp_type rsp_payload;

   decode_scoreboard sb = new();
   bit               steady_flow;
   int unsigned      cycle_count;

   x86_opcode_length_decode dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      if (steady_flow) return 0;
      return $urandom_range(10, 0);
   endfunction

   function automatic xold_pkg::req_type make_req(logic [7:0] code);
      xold_pkg::req_type req;
      req.opcode_byte  = code;
      req.addr_size_32 = 1'($urandom_range(1, 0));
      req.oper_size_32 = 1'($urandom_range(1, 0));
      return req;
   endfunction

   function automatic xold_pkg::req_type fixed_req(logic [7:0] code, logic a32, logic o32);
      xold_pkg::req_type req;
      req.opcode_byte  = code;
      req.addr_size_32 = a32;
      req.oper_size_32 = o32;
      return req;
   endfunction

   task automatic send_request(xold_pkg::req_type req);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = req;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid === 1'b1 && req_ready === 1'b1) sb.note_request(req_payload);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) sb.check_response(rsp_payload);
      end
   end

   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      repeat (8) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      xold_pkg::req_type directed_q[$];
      int unsigned       sent;
      int unsigned       pick;
      bit                drained_once;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      steady_flow  = 1'b0;
      drained_once = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      directed_q = '{
         fixed_req(8'h00, 1'b0, 1'b0), fixed_req(8'hFF, 1'b1, 1'b1),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b0, 1'b0),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b1, 1'b0),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b0, 1'b1), fixed_req(8'h01, 1'b0, 1'b1),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b1, 1'b1), fixed_req(8'hC7, 1'b1, 1'b1),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b1, 1'b0), fixed_req(8'h80, 1'b1, 1'b0),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b0, 1'b0), fixed_req(8'hBA, 1'b0, 1'b0),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b1, 1'b1), fixed_req(8'h9A, 1'b1, 1'b1),
         fixed_req(xold_pkg::ESCAPE_CODE, 1'b0, 1'b0), fixed_req(8'hC8, 1'b0, 1'b0),
         fixed_req(xold_pkg::CALL_FAR_CODE, 1'b1, 1'b0),
         fixed_req(xold_pkg::JMP_FAR_CODE, 1'b0, 1'b1),
         fixed_req(xold_pkg::RET_IMM_CODE, 1'b0, 1'b0),
         fixed_req(xold_pkg::RETF_IMM_CODE, 1'b1, 1'b1),
         fixed_req(xold_pkg::ENTER_CODE, 1'b0, 1'b1),
         fixed_req(8'h05, 1'b0, 1'b1), fixed_req(8'h05, 1'b1, 1'b0),
         fixed_req(8'hA1, 1'b1, 1'b0), fixed_req(8'hA1, 1'b0, 1'b1)
      };
      foreach (directed_q[i]) send_request(directed_q[i]);
      drain_responses();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady_flow = ((sent / 150) % 4) == 3;
         if (sent >= RANDOM_ITEMS / 2 && !drained_once) begin
            drain_responses();
            drained_once = 1'b1;
         end
         pick = $urandom_range(99, 0);
         if (pick < 40) begin
            send_request(make_req(xold_pkg::ESCAPE_CODE));
            send_request(make_req(8'($urandom_range(255, 0))));
            sent += 2;
         end else if (pick < 45) begin
            send_request(make_req(xold_pkg::ESCAPE_CODE));
            sent += 1;
         end else begin
            send_request(make_req(8'($urandom_range(255, 0))));
            sent += 1;
         end
      end

      steady_flow = 1'b0;
      drain_responses();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
